@@ hw/rtl/pfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Page frame blitter package
// Shared constants, operation codes and transfer structs of the page frame
// drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

  // Frame store geometry: pages of eight vertical pixels per byte.
  localparam int unsigned MAX_COLUMNS = 128;
  localparam int unsigned MAX_PAGES   = 8;
  localparam int unsigned PAGE_BITS   = 8;
  localparam int unsigned MAX_ROWS    = MAX_PAGES * PAGE_BITS;
  localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
  localparam int unsigned PAGE_W      = $clog2(MAX_PAGES);
  localparam int unsigned ADDR_W      = COL_W + PAGE_W;
  localparam int unsigned MEM_DEPTH   = MAX_COLUMNS * MAX_PAGES;

  // Field widths of the command and result transfers.
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POSX_W  = 7;
  localparam int unsigned POSY_W  = 6;
  localparam int unsigned SIZEH_W = 7;
  localparam int unsigned SIZEW_W = 8;
  localparam int unsigned ICOL_W  = 7;
  localparam int unsigned IPAGE_W = 3;
  localparam int unsigned BYTE_W  = 8;

  // Configuration registers.
  localparam int unsigned COLS_W     = 8;
  localparam int unsigned ROWS_W     = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [COLS_W-1:0] COLS_RESET = 8'd128;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } pfb_cfg_e;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET   = 3'd0,
    FN_FILL  = 3'd1,
    FN_BLIT  = 3'd2,
    FN_CLEAR = 3'd3,
    FN_READ  = 3'd4
  } pfb_func_e;

  // One command.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POSX_W-1:0]  pos_x;
    logic [POSY_W-1:0]  pos_y;
    logic [SIZEH_W-1:0] size_h;
    logic [SIZEW_W-1:0] size_w;
    logic [ICOL_W-1:0]  image_col;
    logic [IPAGE_W-1:0] image_page;
    logic [BYTE_W-1:0]  image_byte;
    logic               invert;
    logic               keep_existing;
  } pfb_item_t;

  // One result.
  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              out_of_frame;
  } pfb_result_t;

  // Access to the frame store: a read, or a masked write merged with the
  // byte read in the previous cycle.
  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] en;
    logic [BYTE_W-1:0] val;
  } pfb_mem_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfb_store.sv @@
// ----------------------------------------------------------------------------
// Page frame store
// Single-port synchronous byte memory with a registered read and a bit-masked
// write that merges into the byte fetched by the preceding read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_store import pfb_pkg::*; (
  input  logic              clk_i,
  input  pfb_mem_req_t      req_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [MEM_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [BYTE_W-1:0] merged;

  // Bits under the enable mask take the new value, the rest keep the old.
  assign merged = (rdata_q & ~req_i.en) | (req_i.val & req_i.en);

  // Memory array and its read register.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
    if (req_i.we) begin
      mem_q[req_i.addr] <= merged;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/pfb_seq.sv @@
// ----------------------------------------------------------------------------
// Page frame sequencer
// Decodes a command into a clipped rectangle of store bytes and walks it with
// read-modify-write accesses; also runs the clearing sweep and frame reads.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_seq import pfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  pfb_item_t         item_i,
  input  logic [COLS_W-1:0] cols_i,
  input  logic [ROWS_W-1:0] rows_i,
  output pfb_mem_req_t      mem_req_o,
  input  logic [BYTE_W-1:0] mem_rdata_i,
  output logic              done_o,
  output pfb_result_t       result_o
);

  // Column sums need one bit more than the column count, row sums likewise.
  localparam int unsigned X_W     = COLS_W + 1;
  localparam int unsigned Y_W     = ROWS_W + 1;
  localparam int unsigned PPAGE_W = Y_W - 3;
  localparam int unsigned PAT_W   = 2 * BYTE_W;
  localparam int unsigned PIX_W   = PAGE_W + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_RD,
    S_WR,
    S_FETCH,
    S_RESP
  } state_e;

  state_e            state_q;
  logic              done_q;
  logic              done_d;
  logic              rep_q;
  pfb_result_t       res_q;
  logic [PAGE_W-1:0] page_q;
  logic [COL_W-1:0]  col_q;

  // Walk parameters held for the duration of a drawing command.
  logic [COL_W-1:0]   col_lo_q;
  logic [COL_W-1:0]   col_last_q;
  logic [PAGE_W-1:0]  page_last_q;
  logic [PIX_W-1:0]   row_lo_q;
  logic [Y_W-1:0]     row_hi_q;
  logic [PAT_W-1:0]   pat_q;
  logic [PPAGE_W-1:0] pat_page_q;
  logic               use_pat_q;
  logic               keep_q;

  // Decode signals.
  logic [COLS_W-1:0] cols_use;
  logic [ROWS_W-1:0] rows_use;
  logic [X_W-1:0]    blit_x;
  logic [Y_W-1:0]    img_row0;
  logic [Y_W-1:0]    img_row_end;
  logic [Y_W-1:0]    img_rows_lim;
  logic              img_hit;
  logic [Y_W-1:0]    py;
  logic [X_W-1:0]    col_lo;
  logic [X_W-1:0]    col_end;
  logic [X_W-1:0]    col_hi;
  logic [Y_W-1:0]    row_lo;
  logic [Y_W-1:0]    row_end;
  logic [Y_W-1:0]    row_hi;
  logic [Y_W-1:0]    row_last;
  logic [X_W-1:0]    col_last;
  logic              use_pat;
  logic              area;
  logic              oof_draw;
  logic              walk_ok;
  logic [Y_W-1:0]    pages_use;
  logic              oof_read;
  logic [PAT_W-1:0]  pat;

  // Per-byte masks during the walk.
  logic [BYTE_W-1:0] row_mask;
  logic [BYTE_W-1:0] pat_byte;
  logic [BYTE_W-1:0] wr_en;
  logic [BYTE_W-1:0] wr_val;
  logic [PIX_W-1:0]  ypix;

  // Frame size in use, limited to the store.
  assign cols_use = (cols_i > COLS_W'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS) : cols_i;
  assign rows_use = (rows_i > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows_i;

  // Image byte position: its rows end at the image height.
  assign py           = Y_W'(item_i.pos_y);
  assign blit_x       = X_W'(item_i.pos_x) + X_W'(item_i.image_col);
  assign img_row0     = Y_W'({item_i.image_page, 3'b000});
  assign img_row_end  = img_row0 + Y_W'(PAGE_BITS);
  assign img_rows_lim = (img_row_end < Y_W'(item_i.size_h)) ? img_row_end
                                                            : Y_W'(item_i.size_h);
  assign img_hit      = img_row0 < Y_W'(item_i.size_h);

  // Addressed rectangle of the drawing commands, end bounds exclusive.
  always_comb begin
    col_lo  = X_W'(item_i.pos_x);
    col_end = X_W'(item_i.pos_x) + X_W'(1);
    row_lo  = py;
    row_end = py + Y_W'(1);
    use_pat = 1'b0;
    case (item_i.func)
      FN_FILL: begin
        col_end = X_W'(item_i.pos_x) + X_W'(item_i.size_w);
        row_end = py + Y_W'(item_i.size_h);
      end
      FN_BLIT: begin
        col_lo  = blit_x;
        col_end = blit_x + X_W'(1);
        row_lo  = py + img_row0;
        row_end = img_hit ? (py + img_rows_lim) : (py + img_row0);
        use_pat = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Clip to the frame and flag anything addressed beyond it.
  assign col_hi   = (col_end > X_W'(cols_use)) ? X_W'(cols_use) : col_end;
  assign row_hi   = (row_end > Y_W'(rows_use)) ? Y_W'(rows_use) : row_end;
  assign area     = (col_lo < col_end) && (row_lo < row_end);
  assign oof_draw = area && ((col_end > X_W'(cols_use)) || (row_end > Y_W'(rows_use)));
  assign walk_ok  = (col_lo < col_hi) && (row_lo < row_hi);
  assign col_last = col_hi - X_W'(1);
  assign row_last = row_hi - Y_W'(1);

  // Read bounds: whole pages in use.
  assign pages_use = (Y_W'(rows_use) + Y_W'(PAGE_BITS - 1)) >> 3;
  assign oof_read  = (X_W'(item_i.pos_x) >= X_W'(cols_use)) ||
                     (Y_W'(item_i.pos_y[POSY_W-1:3]) >= pages_use);

  // Drawn image pixels, shifted to the pixel offset within the first page.
  assign pat = PAT_W'(item_i.image_byte ^ {BYTE_W{item_i.invert}}) << row_lo[2:0];

  // Row window of the current page.
  always_comb begin
    ypix = '0;
    for (int j = 0; j < PAGE_BITS; j++) begin
      ypix        = {page_q, 3'(j)};
      row_mask[j] = (ypix >= row_lo_q) && (Y_W'(ypix) < row_hi_q);
    end
  end

  assign pat_byte = (PPAGE_W'(page_q) == pat_page_q) ? pat_q[BYTE_W-1:0]
                                                    : pat_q[PAT_W-1:BYTE_W];
  assign wr_en    = use_pat_q ? (row_mask & (keep_q ? pat_byte : {BYTE_W{1'b1}}))
                              : row_mask;
  assign wr_val   = use_pat_q ? pat_byte : {BYTE_W{1'b1}};

  // Store access for the current state.
  always_comb begin
    mem_req_o      = '0;
    mem_req_o.addr = {page_q, col_q};
    unique case (state_q)
      S_CLR: begin
        mem_req_o.we  = 1'b1;
        mem_req_o.en  = {BYTE_W{1'b1}};
        mem_req_o.val = '0;
      end
      S_RD, S_FETCH: begin
        mem_req_o.re = 1'b1;
      end
      S_WR: begin
        mem_req_o.we  = 1'b1;
        mem_req_o.en  = wr_en;
        mem_req_o.val = wr_val;
      end
      default: begin
      end
    endcase
  end

  // Result strobe for the cycle that follows the coming edge.
  always_comb begin
    done_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (item_i.func)
            FN_SET, FN_FILL, FN_BLIT: done_d = !walk_ok;
            FN_CLEAR:                 done_d = 1'b0;
            FN_READ:                  done_d = oof_read;
            default:                  done_d = 1'b1;
          endcase
        end
      end
      S_CLR:   done_d = rep_q && (&{page_q, col_q});
      S_WR:    done_d = (col_q == col_last_q) && (page_q == page_last_q);
      S_RESP:  done_d = 1'b1;
      default: done_d = 1'b0;
    endcase
  end

  // Control state, walk position and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      done_q  <= 1'b0;
      rep_q   <= 1'b0;
      res_q   <= '0;
      page_q  <= '0;
      col_q   <= '0;
    end else begin
      done_q <= done_d;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            case (item_i.func)
              FN_SET, FN_FILL, FN_BLIT: begin
                res_q  <= '{read_data: '0, out_of_frame: oof_draw};
                col_q  <= col_lo[COL_W-1:0];
                page_q <= row_lo[PIX_W-1:3];
                if (walk_ok) begin
                  state_q <= S_RD;
                end
              end
              FN_CLEAR: begin
                res_q   <= '0;
                col_q   <= '0;
                page_q  <= '0;
                rep_q   <= 1'b1;
                state_q <= S_CLR;
              end
              FN_READ: begin
                res_q  <= '{read_data: '0, out_of_frame: oof_read};
                col_q  <= item_i.pos_x[COL_W-1:0];
                page_q <= item_i.pos_y[POSY_W-1:3];
                if (!oof_read) begin
                  state_q <= S_FETCH;
                end
              end
              default: begin
                res_q <= '0;
              end
            endcase
          end
        end
        S_CLR: begin
          {page_q, col_q} <= {page_q, col_q} + ADDR_W'(1);
          if (&{page_q, col_q}) begin
            state_q <= S_IDLE;
            rep_q   <= 1'b0;
          end
        end
        S_RD: begin
          state_q <= S_WR;
        end
        S_WR: begin
          if (col_q == col_last_q) begin
            col_q <= col_lo_q;
            if (page_q == page_last_q) begin
              state_q <= S_IDLE;
            end else begin
              page_q  <= page_q + PAGE_W'(1);
              state_q <= S_RD;
            end
          end else begin
            col_q   <= col_q + COL_W'(1);
            state_q <= S_RD;
          end
        end
        S_FETCH: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          res_q.read_data <= mem_rdata_i;
          state_q         <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Walk parameters, captured when a command is taken.
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == S_IDLE)) begin
      col_lo_q    <= col_lo[COL_W-1:0];
      col_last_q  <= col_last[COL_W-1:0];
      page_last_q <= row_last[PIX_W-1:3];
      row_lo_q    <= row_lo[PIX_W-1:0];
      row_hi_q    <= row_hi;
      pat_q       <= pat;
      pat_page_q  <= row_lo[Y_W-1:3];
      use_pat_q   <= use_pat;
      keep_q      <= item_i.keep_existing;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/page_frame_blit_fill.sv @@
// ----------------------------------------------------------------------------
// Page frame blitter
// Drawing engine for a 1-bit frame store kept as pages of eight vertical
// pixels per byte: set pixel, fill area, blit image byte, clear and read.
//
// A command is taken at a rising edge with start high and busy low. Exactly
// one result follows, shown on result_o for a single cycle while done_o is
// high; the receiver cannot hold it off, and busy is already low in that
// cycle, so the next command may be taken at the edge that ends it.
// Every drawn store byte takes a read and then a write on the single
// port of the frame store memory:
//   set pixel, blit byte: one byte (a blit spanning two pages: two),
//   none when nothing addressed lands in the frame,
//   fill: each byte of the clipped rectangle in turn,
//   read: one byte read and no write, none when it lies outside the frame,
//   clear: every byte written with no read, one byte written per cycle.
// After reset the store is cleared by the same sweep: busy stays high for
// the whole sweep and no result is given. The frame size registers are written
// over the cfg transfer channel, which is always ready; they reset to the
// full frame of 128 columns by 64 rows.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_blit_fill import pfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pfb_item_t             item_i,
  output logic                  done_o,
  output pfb_result_t           result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  pfb_mem_req_t      mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  // Frame size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLUMNS: cols_q <= cfg_data_i[COLS_W-1:0];
        CFG_ROWS:    rows_q <= cfg_data_i[ROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Command sequencer.
  pfb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .item_i      (item_i),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // Frame store.
  pfb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pfb_checker.sv @@
// ----------------------------------------------------------------------------
// Page frame blitter checker
// Port-level assertions on the command and result transfers, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_checker import pfb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input pfb_result_t result_o
);

  // A result is only given once the engine is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A taken command either keeps the engine busy or answers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("command taken without work or result");

  // The engine only becomes busy by taking a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a command transfer");

  // A flagged result never carries frame data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.out_of_frame) |-> (result_o.read_data == '0))
    else $error("out-of-frame result with non-zero data");

endmodule

bind page_frame_blit_fill pfb_checker u_pfb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
